@@ hdl/rdca_pkg.sv @@
// ============================================================================
// rdca_pkg
// shared types and constants of the rx descriptor chain assembler
// ============================================================================
`default_nettype none

package rdca_pkg;

    localparam int MAX_SEGMENTS_DEF  = 5;
    localparam int MAX_RING_LOG2_DEF = 12;
    localparam int MIN_RING_LOG2     = 3;
    localparam int RING_LOG2_RESET   = 9;

    localparam int SEG_LEN_W   = 14;
    localparam int FLOW_ID_W   = 32;
    localparam int HEAD_SLOT_W = 12;
    localparam int TAIL_LEN_W  = 16;
    localparam int TAIL_SUM_W  = 17;
    localparam int SEGS_W      = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 4;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_IDLE    = 2'd1,
        ST_REWOUND = 2'd2,
        ST_DROPPED = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RING_LOG2 = 2'd0,
        CFG_L4_COMP   = 2'd1,
        CFG_L4_CORR   = 2'd2,
        CFG_FLOW_EN   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] ring_size_log2;
        logic                  tmpl_l4_computed;
        logic                  tmpl_l4_correct;
        logic                  flow_enable;
    } t_cfg;

    typedef struct packed {
        logic                 desc_done;
        logic                 end_of_packet;
        logic                 flow_marked;
        logic                 ip_cksum_error;
        logic                 l3l4_parsed;
        logic                 l4_cksum_error;
        logic [SEG_LEN_W-1:0] seg_length;
        logic [FLOW_ID_W-1:0] flow_id;
    } t_desc;

    typedef struct packed {
        t_status                status;
        logic [HEAD_SLOT_W-1:0] head_slot;
        logic [SEG_LEN_W-1:0]   head_length;
        logic [TAIL_LEN_W-1:0]  tail_length;
        logic [SEGS_W-1:0]      segments;
        logic                   l4_computed;
        logic                   l4_correct;
        logic                   chained;
        logic                   ip_error_seen;
        logic                   packet_flow_marked;
        logic [FLOW_ID_W-1:0]   packet_flow_id;
    } t_pkt;

endpackage

`default_nettype wire

@@ hdl/rdca_chan_if.sv @@
// ============================================================================
// rdca_chan_if
// valid/ready channel carrying one beat of a typed payload
// ============================================================================
`default_nettype none

interface rdca_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ hdl/rdca_cfg.sv @@
// ============================================================================
// rdca_cfg
// configuration registers, written through a plain indexed write port
// ============================================================================
`default_nettype none

module rdca_cfg (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [rdca_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [rdca_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output rdca_pkg::t_cfg                        o_cfg
);

    localparam int DW = rdca_pkg::CFG_DATA_W;

    rdca_pkg::t_cfg   r_cfg;
    rdca_pkg::t_cfg   n_cfg;
    rdca_pkg::t_cfg_idx w_idx;

    assign w_idx = rdca_pkg::t_cfg_idx'(i_cfg_idx);

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (w_idx)
                rdca_pkg::CFG_RING_LOG2: n_cfg.ring_size_log2   = i_cfg_data;
                rdca_pkg::CFG_L4_COMP:   n_cfg.tmpl_l4_computed = i_cfg_data[0];
                rdca_pkg::CFG_L4_CORR:   n_cfg.tmpl_l4_correct  = i_cfg_data[0];
                rdca_pkg::CFG_FLOW_EN:   n_cfg.flow_enable      = i_cfg_data[0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ring_size_log2   <= DW'(rdca_pkg::RING_LOG2_RESET);
            r_cfg.tmpl_l4_computed <= 1'b0;
            r_cfg.tmpl_l4_correct  <= 1'b0;
            r_cfg.flow_enable      <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ hdl/rdca_chain.sv @@
// ============================================================================
// rdca_chain
// ring pointer and chain state, next-state and result logic per descriptor
// ============================================================================
`default_nettype none

module rdca_chain #(
    parameter int MAX_SEGMENTS  = rdca_pkg::MAX_SEGMENTS_DEF,
    parameter int MAX_RING_LOG2 = rdca_pkg::MAX_RING_LOG2_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire rdca_pkg::t_desc  i_desc,
    input  wire rdca_pkg::t_cfg   i_cfg,
    output logic                  o_res_valid,
    output rdca_pkg::t_pkt        o_res
);

    localparam int PTR_W = MAX_RING_LOG2;
    localparam int SEG_W = $clog2(MAX_SEGMENTS + 1);
    localparam int DW    = rdca_pkg::CFG_DATA_W;
    localparam int HW    = rdca_pkg::HEAD_SLOT_W;
    localparam int LW    = rdca_pkg::SEG_LEN_W;
    localparam int SW    = rdca_pkg::TAIL_SUM_W;
    localparam int TW    = rdca_pkg::TAIL_LEN_W;
    localparam int CW    = rdca_pkg::SEGS_W;
    localparam int FW    = rdca_pkg::FLOW_ID_W;

    logic [PTR_W-1:0] r_ptr,   n_ptr;
    logic [PTR_W-1:0] r_head,  n_head;
    logic             r_chain, n_chain;
    logic [LW-1:0]    r_first, n_first;
    logic [SW-1:0]    r_tail,  n_tail;
    logic [SEG_W-1:0] r_count, n_count;
    logic             r_ipe,   n_ipe;
    logic             r_mark,  n_mark;
    logic [FW-1:0]    r_flow,  n_flow;

    logic [DW-1:0]    w_lg;
    logic [PTR_W-1:0] w_mask;
    logic [PTR_W-1:0] w_slot;
    logic             w_marked;

    always_comb begin
        if (i_cfg.ring_size_log2 < DW'(rdca_pkg::MIN_RING_LOG2)) begin
            w_lg = DW'(rdca_pkg::MIN_RING_LOG2);
        end else if (i_cfg.ring_size_log2 > DW'(MAX_RING_LOG2)) begin
            w_lg = DW'(MAX_RING_LOG2);
        end else begin
            w_lg = i_cfg.ring_size_log2;
        end
        for (int b = 0; b < PTR_W; b++) begin
            w_mask[b] = (DW'(b) < w_lg);
        end
    end

    assign w_slot = r_ptr & w_mask;

    always_comb begin
        n_ptr   = r_ptr;
        n_head  = r_head;
        n_chain = r_chain;
        n_first = r_first;
        n_tail  = r_tail;
        n_count = r_count;
        n_ipe   = r_ipe;
        n_mark  = r_mark;
        n_flow  = r_flow;
        o_res_valid = 1'b0;
        o_res       = '0;
        w_marked    = 1'b0;

        if (!i_desc.desc_done) begin
            o_res_valid = 1'b1;
            n_chain     = 1'b0;
            if (r_chain) begin
                n_ptr        = r_head & w_mask;
                o_res.status = rdca_pkg::ST_REWOUND;
            end else begin
                n_ptr        = w_slot;
                o_res.status = rdca_pkg::ST_IDLE;
            end
            o_res.head_slot = HW'(n_ptr);
        end else begin
            if (!r_chain) begin
                n_head  = w_slot;
                n_first = i_desc.seg_length;
                n_tail  = '0;
                n_count = SEG_W'(1);
                n_ipe   = i_desc.ip_cksum_error;
                n_mark  = i_desc.flow_marked;
                n_flow  = i_desc.flow_id;
            end else begin
                n_tail  = r_tail + SW'(i_desc.seg_length);
                n_count = r_count + SEG_W'(1);
                n_ipe   = r_ipe | i_desc.ip_cksum_error;
            end
            n_ptr = (w_slot + PTR_W'(1)) & w_mask;

            w_marked                 = n_mark & i_cfg.flow_enable;
            o_res.head_slot          = HW'(n_head);
            o_res.head_length        = n_first;
            o_res.tail_length        = n_tail[SW-1] ? {TW{1'b1}} : n_tail[TW-1:0];
            o_res.segments           = CW'(n_count);
            o_res.chained            = (n_count > SEG_W'(1));
            o_res.ip_error_seen      = n_ipe;
            o_res.packet_flow_marked = w_marked;
            o_res.packet_flow_id     = w_marked ? n_flow : '0;

            if (i_desc.end_of_packet) begin
                n_chain           = 1'b0;
                o_res_valid       = 1'b1;
                o_res.status      = rdca_pkg::ST_DONE;
                o_res.l4_computed = i_cfg.tmpl_l4_computed & i_desc.l3l4_parsed;
                o_res.l4_correct  = i_cfg.tmpl_l4_correct & i_desc.l3l4_parsed
                                    & ~i_desc.l4_cksum_error;
            end else if (n_count >= SEG_W'(MAX_SEGMENTS)) begin
                n_chain      = 1'b0;
                o_res_valid  = 1'b1;
                o_res.status = rdca_pkg::ST_DROPPED;
            end else begin
                n_chain = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr   <= '0;
            r_head  <= '0;
            r_chain <= 1'b0;
            r_first <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_ipe   <= 1'b0;
            r_mark  <= 1'b0;
            r_flow  <= '0;
        end else if (i_step) begin
            r_ptr   <= n_ptr;
            r_head  <= n_head;
            r_chain <= n_chain;
            r_first <= n_first;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_ipe   <= n_ipe;
            r_mark  <= n_mark;
            r_flow  <= n_flow;
        end
    end

endmodule

`default_nettype wire

@@ hdl/rx_descriptor_chain_assembler.sv @@
// ============================================================================
// rx_descriptor_chain_assembler
// assembles receive write-back descriptors into packet reports
// ============================================================================
// path: descriptor beat to result beat through the input register, then the
//   result register behind the chain state update
// throughput: one descriptor per cycle while o_pkt.ready does not stall the output
// reset: synchronous active-low; pointer and chain state clear, ring size log2 9
`default_nettype none

module rx_descriptor_chain_assembler #(
    parameter int MAX_SEGMENTS  = rdca_pkg::MAX_SEGMENTS_DEF,
    parameter int MAX_RING_LOG2 = rdca_pkg::MAX_RING_LOG2_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [rdca_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [rdca_pkg::CFG_DATA_W-1:0] i_cfg_data,
    rdca_chan_if.sink                            i_desc,
    rdca_chan_if.source                          o_pkt
);

    localparam int CW = rdca_pkg::SEGS_W;

    rdca_pkg::t_cfg  w_cfg;
    rdca_pkg::t_desc r_in;
    logic            r_in_valid;
    logic            w_advance;
    logic            w_res_valid;
    rdca_pkg::t_pkt  w_res;
    rdca_pkg::t_pkt  r_out;
    logic            r_out_valid;

    rdca_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    assign w_advance    = r_in_valid && (!r_out_valid || o_pkt.ready);
    assign i_desc.ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_desc.ready) begin
            r_in_valid <= i_desc.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_desc.ready && i_desc.valid) begin
            r_in <= i_desc.payload;
        end
    end

    rdca_chain #(
        .MAX_SEGMENTS  (MAX_SEGMENTS),
        .MAX_RING_LOG2 (MAX_RING_LOG2)
    ) u_chain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_advance),
        .i_desc      (r_in),
        .i_cfg       (w_cfg),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_res_valid;
        end else if (o_pkt.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_pkt.valid   = r_out_valid;
    assign o_pkt.payload = r_out;

    // a held input beat stays put until the chain takes it
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_in)))
        else $error("input register lost or changed a waiting beat");

    a_stop_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.status == rdca_pkg::ST_IDLE
                         || r_out.status == rdca_pkg::ST_REWOUND))
        |-> (r_out.segments == '0 && r_out.packet_flow_id == '0
             && !r_out.ip_error_seen))
        else $error("poll stop result carries packet fields");

    a_drop_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == rdca_pkg::ST_DROPPED)
        |-> (r_out.segments == CW'(MAX_SEGMENTS) && !r_out.l4_computed
             && !r_out.l4_correct))
        else $error("dropped chain with wrong segment count or l4 flags");

    a_chained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == rdca_pkg::ST_DONE)
        |-> (r_out.chained == (r_out.segments > CW'(1))))
        else $error("chained flag disagrees with segment count");

endmodule

`default_nettype wire
